/* src/rotated_pixel_framebuffer_writer_top_macros.svh */
// Assertion macros for the rotated pixel framebuffer writer.
// Clock and reset are taken as aclk and aresetn from the including scope.
`ifndef ROTATED_PIXEL_FRAMEBUFFER_WRITER_TOP_MACROS_SVH
`define ROTATED_PIXEL_FRAMEBUFFER_WRITER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RPFW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rpfw assertion failed");
`define RPFW_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("rpfw reset assertion failed");
`else
`define RPFW_ASSERT(lbl, prop)
`define RPFW_ASSERT_NORST(lbl, prop)
`endif
`endif

/* src/rpfw_pkg.sv */
// Shared types and constants for the rotated pixel framebuffer writer.
// No dependencies; used by every module of the block.
package rpfw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 768;
    localparam int MONO_DEPTH = MAX_WIDTH * MAX_HEIGHT / 8;
    localparam int GRAY_DEPTH = MAX_WIDTH * MAX_HEIGHT / 2;
    localparam int MONO_AW    = $clog2(MONO_DEPTH);
    localparam int GRAY_AW    = $clog2(GRAY_DEPTH);

    localparam int POS_W      = 16;
    localparam int COLOUR_W   = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_ADDR_W = 19;
    localparam int BYTE_W     = 8;
    localparam int SUB_W      = 3;
    localparam int ADDR_W     = WIDTH_W + HEIGHT_W;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd800;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 10'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PANEL_WIDTH,
        CFG_PANEL_HEIGHT,
        CFG_ROTATION,
        CFG_PIXEL_MODE
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROT_0,
        ROT_90,
        ROT_180,
        ROT_270
    } rot_t;

    typedef enum logic {
        MODE_MONO,
        MODE_GRAY
    } pix_mode_t;

    typedef struct packed {
        logic load_in;
        logic map_en;
        logic mul_en;
        logic add_en;
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
    } ctrl_status_t;

endpackage

/* src/rotated_pixel_framebuffer_writer_top.sv */
// Channel   Handshake           Payload
// s_        s_valid / s_ready   s_pos_x, s_pos_y, s_colour
// m_        m_valid / m_ready   m_written, m_byte_address, m_byte_value
// cfg_      cfg_wen             cfg_index, cfg_wdata
// After its acceptance a request is stepped by the controller through map, multiply, add,
// read and write on the stores before the next request can be accepted.
// After reset a clearing pass zeroes both stores; s_ready stays low meanwhile.
// A result waits in the output register while m_ready is low; the next request is
// taken meanwhile and holds in its write step until the output register frees.
// Depends on rpfw_pkg, rpfw_ctrl, rpfw_addr, rpfw_store and the macros header.
`include "rotated_pixel_framebuffer_writer_top_macros.svh"
module rotated_pixel_framebuffer_writer_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [rpfw_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [rpfw_pkg::POS_W-1:0]     s_pos_y,
    input  logic [rpfw_pkg::COLOUR_W-1:0]         s_colour,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_written,
    output logic [rpfw_pkg::OUT_ADDR_W-1:0]       m_byte_address,
    output logic [rpfw_pkg::BYTE_W-1:0]           m_byte_value,
    input  logic                                  cfg_wen,
    input  logic [rpfw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rpfw_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    rpfw_pkg::ctrl_cmd_t            cmd;
    rpfw_pkg::ctrl_status_t         status;
    logic [rpfw_pkg::ADDR_W-1:0]    addr;
    logic [rpfw_pkg::SUB_W-1:0]     sub;
    logic                           clip;
    logic [rpfw_pkg::COLOUR_W-1:0]  colour;
    rpfw_pkg::pix_mode_t            pixel_mode;

    rpfw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rpfw_addr u_addr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_colour   (s_colour),
        .cmd        (cmd),
        .addr       (addr),
        .sub        (sub),
        .clip       (clip),
        .colour     (colour),
        .pixel_mode (pixel_mode)
    );

    rpfw_store u_store (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .addr           (addr),
        .sub            (sub),
        .clip           (clip),
        .colour         (colour),
        .pixel_mode     (pixel_mode),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_written      (m_written),
        .m_byte_address (m_byte_address),
        .m_byte_value   (m_byte_value)
    );

    `RPFW_ASSERT(a_one_in_flight, (s_valid && s_ready) |=> !s_ready)
    `RPFW_ASSERT(a_write_fills_slot, cmd.wr_en |=> m_valid)
    `RPFW_ASSERT(a_clipped_zero, (m_valid && !m_written) |-> (m_byte_address == '0 && m_byte_value == '0))
    `RPFW_ASSERT(a_clear_blocks_intake, cmd.clr_en |-> !s_ready)
    `RPFW_ASSERT_NORST(a_reset_quiet, !aresetn |=> (!s_ready && !m_valid))

endmodule

/* src/rpfw_ctrl.sv */
// Controller state machine: clearing pass, request intake and stage sequencing.
// Depends on rpfw_pkg for the command and status structs.
module rpfw_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rpfw_pkg::ctrl_status_t status,
    output rpfw_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_ADD,
        ST_READ,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    assign s_ready = s_ready_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (status.clr_done) begin
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            ST_IDLE: begin
                cmd.load_in = s_valid && s_ready_reg;
                if (s_valid && s_ready_reg) begin
                    state_next   = ST_MAP;
                    s_ready_next = 1'b0;
                end
            end
            ST_MAP: begin
                cmd.map_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_en = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.wr_en = status.out_free;
                if (status.out_free) begin
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_CLEAR;
                s_ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

endmodule

/* src/rpfw_addr.sv */
// Address datapath: configuration registers, clipping, rotation and byte address.
// Depends on rpfw_pkg; driven by commands from rpfw_ctrl.
module rpfw_addr (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [rpfw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rpfw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic signed [rpfw_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [rpfw_pkg::POS_W-1:0]     s_pos_y,
    input  logic [rpfw_pkg::COLOUR_W-1:0]         s_colour,
    input  rpfw_pkg::ctrl_cmd_t                   cmd,
    output logic [rpfw_pkg::ADDR_W-1:0]           addr,
    output logic [rpfw_pkg::SUB_W-1:0]            sub,
    output logic                                  clip,
    output logic [rpfw_pkg::COLOUR_W-1:0]         colour,
    output rpfw_pkg::pix_mode_t                   pixel_mode
);

    localparam int PW  = rpfw_pkg::POS_W;
    localparam int WW  = rpfw_pkg::WIDTH_W;
    localparam int HW  = rpfw_pkg::HEIGHT_W;
    localparam int SW  = rpfw_pkg::WIDTH_W - 1;
    localparam int PRW = SW + rpfw_pkg::HEIGHT_W;
    localparam int AW  = rpfw_pkg::ADDR_W;
    localparam int SUB_WL = rpfw_pkg::SUB_W;

    logic [WW-1:0]          width_reg;
    logic [HW-1:0]          height_reg;
    rpfw_pkg::rot_t         rot_reg;
    rpfw_pkg::pix_mode_t    mode_reg;

    logic [PW-1:0]          x_reg, y_reg;
    logic [rpfw_pkg::COLOUR_W-1:0] colour_reg;
    logic                   clip_reg, clip_next;
    logic [WW-1:0]          px_reg, px_next;
    logic [HW-1:0]          py_reg, py_next;
    logic [WW-1:0]          lw, lh;
    logic [PRW-1:0]         prod_reg;
    logic [SW-1:0]          off_reg, stride;
    logic [SUB_WL-1:0]      sub_reg;
    logic [AW-1:0]          addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rpfw_pkg::RESET_WIDTH;
            height_reg <= rpfw_pkg::RESET_HEIGHT;
            rot_reg    <= rpfw_pkg::ROT_0;
            mode_reg   <= rpfw_pkg::MODE_MONO;
        end else if (cfg_wen) begin
            unique case (rpfw_pkg::cfg_index_t'(cfg_index))
                rpfw_pkg::CFG_PANEL_WIDTH:  width_reg  <= cfg_wdata[WW-1:0];
                rpfw_pkg::CFG_PANEL_HEIGHT: height_reg <= cfg_wdata[HW-1:0];
                rpfw_pkg::CFG_ROTATION:     rot_reg    <= rpfw_pkg::rot_t'(cfg_wdata[1:0]);
                rpfw_pkg::CFG_PIXEL_MODE:   mode_reg   <= rpfw_pkg::pix_mode_t'(cfg_wdata[0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        lw = rot_reg[0] ? WW'(height_reg) : width_reg;
        lh = rot_reg[0] ? width_reg : WW'(height_reg);
        clip_next = x_reg[PW-1] || y_reg[PW-1] ||
                    (x_reg >= PW'(lw)) || (y_reg >= PW'(lh));
        unique case (rot_reg)
            rpfw_pkg::ROT_90: begin
                px_next = width_reg - WW'(1) - y_reg[WW-1:0];
                py_next = x_reg[HW-1:0];
            end
            rpfw_pkg::ROT_180: begin
                px_next = width_reg - WW'(1) - x_reg[WW-1:0];
                py_next = height_reg - HW'(1) - y_reg[HW-1:0];
            end
            rpfw_pkg::ROT_270: begin
                px_next = y_reg[WW-1:0];
                py_next = height_reg - HW'(1) - x_reg[HW-1:0];
            end
            default: begin
                px_next = x_reg[WW-1:0];
                py_next = y_reg[HW-1:0];
            end
        endcase
        stride = (mode_reg == rpfw_pkg::MODE_GRAY) ? SW'(width_reg >> 1)
                                                   : SW'(width_reg >> 3);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg      <= s_pos_x;
            y_reg      <= s_pos_y;
            colour_reg <= s_colour;
        end
        if (cmd.map_en) begin
            clip_reg <= clip_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= PRW'(stride) * PRW'(py_reg);
            off_reg  <= (mode_reg == rpfw_pkg::MODE_GRAY) ? SW'(px_reg >> 1)
                                                          : SW'(px_reg >> 3);
            sub_reg  <= px_reg[SUB_WL-1:0];
        end
        if (cmd.add_en) begin
            addr_reg <= AW'(prod_reg) + AW'(off_reg);
        end
    end

    assign addr       = addr_reg;
    assign sub        = sub_reg;
    assign clip       = clip_reg;
    assign colour     = colour_reg;
    assign pixel_mode = mode_reg;

endmodule

/* src/rpfw_store.sv */
// Framebuffer stores with clearing pass, read-modify-write and result register.
// Depends on rpfw_pkg; driven by commands from rpfw_ctrl, address from rpfw_addr.
module rpfw_store (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rpfw_pkg::ctrl_cmd_t                   cmd,
    output rpfw_pkg::ctrl_status_t                status,
    input  logic [rpfw_pkg::ADDR_W-1:0]           addr,
    input  logic [rpfw_pkg::SUB_W-1:0]            sub,
    input  logic                                  clip,
    input  logic [rpfw_pkg::COLOUR_W-1:0]         colour,
    input  rpfw_pkg::pix_mode_t                   pixel_mode,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_written,
    output logic [rpfw_pkg::OUT_ADDR_W-1:0]       m_byte_address,
    output logic [rpfw_pkg::BYTE_W-1:0]           m_byte_value
);

    localparam int AW  = rpfw_pkg::ADDR_W;
    localparam int MAW = rpfw_pkg::MONO_AW;
    localparam int GAW = rpfw_pkg::GRAY_AW;
    localparam int BW  = rpfw_pkg::BYTE_W;
    localparam int OAW = rpfw_pkg::OUT_ADDR_W;
    localparam int MonoDepth = rpfw_pkg::MONO_DEPTH;
    localparam int GrayDepth = rpfw_pkg::GRAY_DEPTH;

    logic [BW-1:0]  mono_mem [MonoDepth];
    logic [BW-1:0]  gray_mem [GrayDepth];

    logic [GAW-1:0] clr_cnt_reg;
    logic           is_gray, ok_next, ok_reg;
    logic           mono_we, mono_re, gray_we, gray_re;
    logic [MAW-1:0] mono_waddr;
    logic [GAW-1:0] gray_waddr;
    logic [BW-1:0]  mono_rdata_reg, gray_rdata_reg;
    logic [BW-1:0]  mono_new, gray_new, new_byte, wdata;
    logic           m_valid_reg;
    logic           m_written_reg;
    logic [OAW-1:0] m_addr_reg;
    logic [BW-1:0]  m_value_reg;

    assign is_gray = (pixel_mode == rpfw_pkg::MODE_GRAY);
    assign ok_next = !clip && (is_gray ? (addr < AW'(GrayDepth)) : (addr < AW'(MonoDepth)));

    assign status.clr_done = (clr_cnt_reg == GAW'(GrayDepth - 1));
    assign status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        mono_new      = mono_rdata_reg;
        mono_new[sub] = |colour;
        gray_new = sub[0] ? {gray_rdata_reg[7:4], 1'b0, colour[2:0]}
                          : {1'b0, colour[2:0], gray_rdata_reg[3:0]};
        new_byte = is_gray ? gray_new : mono_new;
        wdata    = cmd.clr_en ? '0 : new_byte;
    end

    assign mono_re    = cmd.rd_en && ok_next && !is_gray;
    assign gray_re    = cmd.rd_en && ok_next && is_gray;
    assign mono_we    = (cmd.clr_en && (clr_cnt_reg < GAW'(MonoDepth))) ||
                        (cmd.wr_en && ok_reg && !is_gray);
    assign gray_we    = cmd.clr_en || (cmd.wr_en && ok_reg && is_gray);
    assign mono_waddr = cmd.clr_en ? clr_cnt_reg[MAW-1:0] : addr[MAW-1:0];
    assign gray_waddr = cmd.clr_en ? clr_cnt_reg : addr[GAW-1:0];

    always_ff @(posedge aclk) begin
        if (mono_we) begin
            mono_mem[mono_waddr] <= wdata;
        end
        if (mono_re) begin
            mono_rdata_reg <= mono_mem[addr[MAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (gray_we) begin
            gray_mem[gray_waddr] <= wdata;
        end
        if (gray_re) begin
            gray_rdata_reg <= gray_mem[addr[GAW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_en && !status.clr_done) begin
                clr_cnt_reg <= clr_cnt_reg + GAW'(1);
            end
            if (cmd.wr_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            ok_reg <= ok_next;
        end
        if (cmd.wr_en) begin
            m_written_reg <= ok_reg;
            m_addr_reg    <= ok_reg ? addr[OAW-1:0] : '0;
            m_value_reg   <= ok_reg ? new_byte : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_written      = m_written_reg;
    assign m_byte_address = m_addr_reg;
    assign m_byte_value   = m_value_reg;

endmodule

/* tb/rpfw_result_checker.sv */
// Result checker for the rotated pixel framebuffer writer: keeps its own panel settings and
// framebuffer copies, predicts the byte written by each request and compares the results.
// Depends on rpfw_pkg only; instantiated by tb_top beside the block.
`timescale 1ns / 1ps
module rpfw_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [rpfw_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [rpfw_pkg::POS_W-1:0] s_pos_y,
    input  logic [rpfw_pkg::COLOUR_W-1:0]     s_colour,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_written,
    input  logic [rpfw_pkg::OUT_ADDR_W-1:0]   m_byte_address,
    input  logic [rpfw_pkg::BYTE_W-1:0]       m_byte_value,
    input  logic                              cfg_wen,
    input  logic [rpfw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpfw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                mismatch_count,
    output int                                pending_count,
    output int                                stored_count,
    output int                                clipped_count
);
    import rpfw_pkg::*;

    typedef struct packed {
        logic                  written;
        logic [OUT_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]     value;
    } byte_write_t;

    bit [BYTE_W-1:0] mono_bytes [MONO_DEPTH];
    bit [BYTE_W-1:0] gray_bytes [GRAY_DEPTH];

    logic [WIDTH_W-1:0]  panel_w = RESET_WIDTH;
    logic [HEIGHT_W-1:0] panel_h = RESET_HEIGHT;
    rot_t                rot     = ROT_0;
    pix_mode_t           mode    = MODE_MONO;

    byte_write_t pending_writes [$];
    int fails   = 0;
    int stored  = 0;
    int clipped = 0;

    function automatic byte_write_t paint_pixel(int x, int y, logic [COLOUR_W-1:0] colour);
        byte_write_t res;
        int w, h, lw, lh, phys_x, phys_y;
        int unsigned addr;
        logic [BYTE_W-1:0] cur;
        res = '0;
        w = panel_w;
        h = panel_h;
        lw = rot[0] ? h : w;
        lh = rot[0] ? w : h;
        if (x < 0 || y < 0 || x >= lw || y >= lh)
            return res;
        case (rot)
            ROT_90: begin
                phys_x = w - 1 - y;
                phys_y = x;
            end
            ROT_180: begin
                phys_x = w - 1 - x;
                phys_y = h - 1 - y;
            end
            ROT_270: begin
                phys_x = y;
                phys_y = h - 1 - x;
            end
            default: begin
                phys_x = x;
                phys_y = y;
            end
        endcase
        if (mode == MODE_MONO) begin
            addr = (w >> 3) * phys_y + (phys_x >> 3);
            if (addr >= MONO_DEPTH)
                return res;
            cur = mono_bytes[addr];
            cur[phys_x[2:0]] = (colour != '0);
            mono_bytes[addr] = cur;
        end else begin
            addr = (w >> 1) * phys_y + (phys_x >> 1);
            if (addr >= GRAY_DEPTH)
                return res;
            cur = gray_bytes[addr];
            if (phys_x[0])
                cur[3:0] = {1'b0, colour[2:0]};
            else
                cur[7:4] = {1'b0, colour[2:0]};
            gray_bytes[addr] = cur;
        end
        res.written = 1'b1;
        res.addr    = addr[OUT_ADDR_W-1:0];
        res.value   = cur;
        return res;
    endfunction

    always @(posedge aclk) begin
        byte_write_t want;
        byte_write_t got;
        if (!aresetn) begin
            panel_w = RESET_WIDTH;
            panel_h = RESET_HEIGHT;
            rot     = ROT_0;
            mode    = MODE_MONO;
            pending_writes.delete();
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_PANEL_WIDTH:  panel_w = cfg_wdata[WIDTH_W-1:0];
                    CFG_PANEL_HEIGHT: panel_h = cfg_wdata[HEIGHT_W-1:0];
                    CFG_ROTATION:     rot     = rot_t'(cfg_wdata[1:0]);
                    CFG_PIXEL_MODE:   mode    = pix_mode_t'(cfg_wdata[0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = paint_pixel(s_pos_x, s_pos_y, s_colour);
                if (want.written)
                    stored++;
                else
                    clipped++;
                pending_writes.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.written = m_written;
                got.addr    = m_byte_address;
                got.value   = m_byte_value;
                if (pending_writes.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with no request: written=%0b addr=%0d value=%02h",
                                 $time, got.written, got.addr, got.value);
                end else begin
                    want = pending_writes.pop_front();
                    if (got.written !== want.written || got.addr !== want.addr ||
                        got.value !== want.value) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch: written %0b/%0b addr %0d/%0d value %02h/%02h",
                                     $time, want.written, got.written, want.addr, got.addr,
                                     want.value, got.value);
                    end
                end
            end
        end
        mismatch_count <= fails;
        pending_count  <= pending_writes.size();
        stored_count   <= stored;
        clipped_count  <= clipped;
    end

endmodule

/* tb/tb_top.sv */
// Testbench top for the rotated pixel framebuffer writer: drives pixel requests, panel
// settings and result backpressure, watches for a hang and reports the verdict.
// Depends on rpfw_pkg, rpfw_result_checker and rotated_pixel_framebuffer_writer_top.
`timescale 1ns / 1ps
module tb_top;
    import rpfw_pkg::*;

    // The clearing pass after reset alone keeps both channels quiet for its whole duration.
    localparam int QUIET_LIMIT = 1_200_000;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_valid  = 1'b0;
    logic                      s_ready;
    logic signed [POS_W-1:0]   s_pos_x  = '0;
    logic signed [POS_W-1:0]   s_pos_y  = '0;
    logic [COLOUR_W-1:0]       s_colour = '0;
    logic                      m_valid;
    logic                      m_ready  = 1'b0;
    logic                      m_written;
    logic [OUT_ADDR_W-1:0]     m_byte_address;
    logic [BYTE_W-1:0]         m_byte_value;
    logic                      cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

    int mismatch_count, pending_count, stored_count, clipped_count;
    int quiet_cycles  = 0;
    int sent_requests = 0;
    int panel_phases  = 1;
    int span_x        = 800;
    int span_y        = 600;
    int calm_left     = 0;

    int fixed_w    [9] = '{8, 0, 800, 13, 13, 2047, 2047, 1024, 1024};
    int fixed_h    [9] = '{1, 600, 0, 5, 5, 1023, 1023, 768, 768};
    int fixed_rot  [9] = '{0, 1, 2, 3, 1, 1, 0, 2, 3};
    int fixed_mode [9] = '{0, 0, 1, 0, 1, 1, 0, 0, 1};

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    rotated_pixel_framebuffer_writer_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_colour       (s_colour),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_written      (m_written),
        .m_byte_address (m_byte_address),
        .m_byte_value   (m_byte_value),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    rpfw_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_colour       (s_colour),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_written      (m_written),
        .m_byte_address (m_byte_address),
        .m_byte_value   (m_byte_value),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .stored_count   (stored_count),
        .clipped_count  (clipped_count)
    );

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 4) begin
            calm_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 13);
    endfunction

    function automatic logic [POS_W-1:0] pick_coord(int span);
        int r;
        int corner;
        r = $urandom_range(99);
        if (r < 8)
            return POS_W'($urandom);
        if (span <= 0 || r < 24) begin
            corner = $urandom_range(3);
            case (corner)
                0: return POS_W'(-1);
                1: return '0;
                2: return POS_W'(span - 1);
                default: return POS_W'(span);
            endcase
        end
        return POS_W'($urandom_range(span - 1));
    endfunction

    function automatic logic [COLOUR_W-1:0] pick_colour();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return '0;
        if (r < 60)
            return COLOUR_W'($urandom_range(7));
        return COLOUR_W'($urandom);
    endfunction

    task automatic send_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                              logic [COLOUR_W-1:0] colour);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_pos_x  <= x;
        s_pos_y  <= y;
        s_colour <= colour;
        do @(posedge aclk); while (!s_ready);
        sent_requests++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, int data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[CFG_DATA_W-1:0];
        @(posedge aclk);
    endtask

    task automatic set_panel(int w, int h, rot_t r, pix_mode_t m);
        settle();
        write_reg(CFG_PANEL_WIDTH, w);
        write_reg(CFG_PANEL_HEIGHT, h);
        write_reg(CFG_ROTATION, int'(r));
        write_reg(CFG_PIXEL_MODE, int'(m));
        cfg_wen <= 1'b0;
        span_x = r[0] ? h : w;
        span_y = r[0] ? w : h;
        panel_phases++;
    endtask

    task automatic run_strokes(int count);
        logic [POS_W-1:0] x, y;
        x = '0;
        y = '0;
        repeat (count) begin
            if ($urandom_range(3) == 0) begin
                x = x + 1'b1;
            end else begin
                x = pick_coord(span_x);
                y = pick_coord(span_y);
            end
            send_pixel(x, y, pick_colour());
        end
    endtask

    initial begin : result_backpressure
        int run, stall;
        @(posedge aclk);
        forever begin
            run = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(30, 1);
            stall = $urandom_range(99);
            if (stall < 20)
                stall = 0;
            else if (stall < 90)
                stall = $urandom_range(3, 1);
            else
                stall = $urandom_range(50, 10);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        int w, h, r;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_pixel(0, 0, 1);
        send_pixel(1, 0, 1);
        send_pixel(7, 0, 16'hFFFF);
        send_pixel(7, 0, 0);
        send_pixel(8, 0, 16'h8000);
        send_pixel(799, 599, 1);
        send_pixel(800, 0, 1);
        send_pixel(0, 600, 1);
        send_pixel(-1, 5, 1);
        send_pixel(5, -1, 1);
        send_pixel(-32768, -32768, 1);
        send_pixel(32767, 32767, 1);
        send_pixel(799, 0, 0);

        set_panel(800, 600, ROT_0, MODE_GRAY);
        send_pixel(0, 0, 7);
        send_pixel(1, 0, 5);
        send_pixel(1, 0, 16'hFFF8);
        send_pixel(2, 3, 3);
        send_pixel(799, 599, 16'hFFFF);
        send_pixel(800, 599, 7);

        for (int i = 0; i < 9; i++) begin
            set_panel(fixed_w[i], fixed_h[i], rot_t'(fixed_rot[i]), pix_mode_t'(fixed_mode[i]));
            run_strokes(30);
        end

        while (sent_requests < 600) begin
            r = $urandom_range(99);
            if (r < 70) begin
                w = $urandom_range(64, 8);
                h = $urandom_range(48, 1);
            end else if (r < 85) begin
                w = 8 * $urandom_range(128, 1);
                h = $urandom_range(768, 1);
            end else begin
                w = $urandom_range(2047);
                h = $urandom_range(1023);
            end
            set_panel(w, h, rot_t'($urandom_range(3)), pix_mode_t'($urandom_range(1)));
            run_strokes(40);
        end

        settle();
        repeat (12) @(posedge aclk);
        $display("Sent %0d pixel requests over %0d panel settings, all rotations and both modes.",
                 sent_requests, panel_phases);
        $display("%0d requests updated a framebuffer byte, %0d were clipped.",
                 stored_count, clipped_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
